>>> rtl/core/rlpsd_pkg.sv
// ----------------------------------------------------------------------------
// rlpsd_pkg
// Shared types and constants of the RGB LED panel scan driver.
// ----------------------------------------------------------------------------
`default_nettype none

package rlpsd_pkg;

    localparam int ROW_BYTES  = 4;
    localparam int PANEL_ROWS = 16;
    localparam int HALF_ROWS  = PANEL_ROWS / 2;
    localparam int COLORS     = 3;
    localparam int ROW_SPAN   = ROW_BYTES * COLORS;
    localparam int STORE_SIZE = PANEL_ROWS * ROW_SPAN;

    // words per color bank: one per row and column group
    localparam int WORDS  = PANEL_ROWS * ROW_BYTES;
    localparam int WIDX_W = $clog2(WORDS);
    localparam int ROW_W  = $clog2(HALF_ROWS);
    localparam int GRP_W  = $clog2(ROW_BYTES + 1);
    localparam int LANES  = 2 * COLORS;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_addr;
        logic [7:0] byte_data;
    } t_in;

    typedef struct packed {
        logic       red_top;
        logic       green_top;
        logic       blue_top;
        logic       red_bottom;
        logic       green_bottom;
        logic       blue_bottom;
        logic [2:0] row_select;
        logic       latch_strobe;
        logic       last;
    } t_out;

    // decoded command word passed from front to back
    typedef struct packed {
        logic              is_scan;
        logic [1:0]        color;
        logic [WIDX_W-1:0] widx;
        logic [7:0]        data;
    } t_cmd;

    // addr / 3 by reciprocal, exact for any 8-bit value
    function automatic logic [7:0] div3(input logic [7:0] addr);
        logic [15:0] prod;
        prod = 16'(addr) * 16'd171;
        return {1'b0, prod[15:9]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rgb_led_panel_scan_driver.sv
// ----------------------------------------------------------------------------
// rgb_led_panel_scan_driver
// Frame store and row-pair scan engine for a 16-row, 1/8-scan RGB panel.
//
// Input channel (i_valid/o_ready, i_data): a write word stores one byte of
// the 192-byte frame store and gives no output; addresses past the store
// are dropped. A scan word produces 32 shift words (top row and the row
// eight below, LSB first, group by group) and then one latch word with
// the row address, after which the row counter advances modulo 8.
// Output channel (o_valid/i_ready, o_data) is a single output register.
// A two-entry queue sits between input decode and the scan engine, so
// input words are taken while a scan is still running.
// The first shift word passes the queue, state register, group read
// register, shifter and output register. A write is done when popped;
// no word is popped during a scan. The shifter sends one bit per cycle
// unless the receiver stalls; one column group is read per store read.
// Reset clears the frame store valid bits (store reads as zero), the row
// counter, the queue and the output valid flag. When the receiver stalls,
// the output word holds and the shifter waits; the queue fills and then
// o_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_panel_scan_driver (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  rlpsd_pkg::t_in   i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output rlpsd_pkg::t_out  o_data
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_avail;
    rlpsd_pkg::t_cmd push_cmd;
    rlpsd_pkg::t_cmd head_cmd;

    rlpsd_front u_front (
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    rlpsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_cmd   (head_cmd)
    );

    rlpsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_avail),
        .i_cmd   (head_cmd),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/rlpsd_front.sv
// ----------------------------------------------------------------------------
// rlpsd_front
// Accepts input words, drops out-of-range writes and splits the byte
// address into color bank and word index.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpsd_front (
    input  wire              i_valid,
    output logic             o_ready,
    input  rlpsd_pkg::t_in   i_data,
    input  wire              i_q_full,
    output logic             o_push,
    output rlpsd_pkg::t_cmd  o_cmd
);

    logic [7:0] quot;
    logic [7:0] rem;
    logic       in_range;

    always_comb begin
        quot     = rlpsd_pkg::div3(i_data.byte_addr);
        rem      = i_data.byte_addr - 8'(quot * 8'd3);
        in_range = (i_data.byte_addr < 8'(rlpsd_pkg::STORE_SIZE));

        o_ready       = !i_q_full;
        o_push        = i_valid && !i_q_full
                        && ((i_data.op == rlpsd_pkg::OP_SCAN) || in_range);
        o_cmd.is_scan = (i_data.op == rlpsd_pkg::OP_SCAN);
        o_cmd.color   = rem[1:0];
        o_cmd.widx    = quot[rlpsd_pkg::WIDX_W-1:0];
        o_cmd.data    = i_data.byte_data;
    end

endmodule

`default_nettype wire

>>> rtl/core/rlpsd_queue.sv
// ----------------------------------------------------------------------------
// rlpsd_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpsd_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  rlpsd_pkg::t_cmd  i_cmd,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_avail,
    output rlpsd_pkg::t_cmd  o_cmd
);

    rlpsd_pkg::t_cmd r_buf [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;

    always_comb begin
        o_full  = (r_cnt == 2'd2);
        o_avail = (r_cnt != 2'd0);
        o_cmd   = r_buf[r_rp];
        n_cnt   = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rlpsd_back.sv
// ----------------------------------------------------------------------------
// rlpsd_back
// Frame store and scan engine: executes writes, and for a scan fetches
// one column group per read, shifts it out bit by bit, then latches.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpsd_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_avail,
    input  rlpsd_pkg::t_cmd  i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output rlpsd_pkg::t_out  o_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // three color banks; each read at top and bottom row
    logic [7:0]                    r_mem [rlpsd_pkg::COLORS][rlpsd_pkg::WORDS];
    logic [rlpsd_pkg::WORDS-1:0]   r_vld [rlpsd_pkg::COLORS];

    logic                          r_state;
    logic [rlpsd_pkg::ROW_W-1:0]   r_row;
    logic [rlpsd_pkg::GRP_W-1:0]   r_fgrp;
    logic [rlpsd_pkg::GRP_W-1:0]   r_sgrp;
    logic [7:0]                    r_rd   [rlpsd_pkg::LANES];
    logic [rlpsd_pkg::LANES-1:0]   r_rd_v;
    logic                          r_rd_vld;
    logic [7:0]                    r_sh   [rlpsd_pkg::LANES];
    logic                          r_sh_full;
    logic [2:0]                    r_bit;
    logic                          r_out_vld;
    rlpsd_pkg::t_out               r_out;
    rlpsd_pkg::t_out               n_out;

    logic                          out_free;
    logic                          sh_adv;
    logic                          sh_last;
    logic                          sh_load;
    logic                          rd_en;
    logic                          latch_go;
    logic                          wr_en;
    logic [rlpsd_pkg::WIDX_W-1:0]  top_idx;
    logic [rlpsd_pkg::WIDX_W-1:0]  bot_idx;

    always_comb begin
        out_free = !r_out_vld || i_ready;
        sh_adv   = r_sh_full && out_free;
        sh_last  = (r_bit == 3'd7);
        sh_load  = r_rd_vld && (!r_sh_full || (sh_adv && sh_last));
        rd_en    = (r_state == ST_SCAN)
                   && (r_fgrp < rlpsd_pkg::GRP_W'(rlpsd_pkg::ROW_BYTES))
                   && (!r_rd_vld || sh_load);
        latch_go = (r_state == ST_SCAN)
                   && (r_sgrp == rlpsd_pkg::GRP_W'(rlpsd_pkg::ROW_BYTES))
                   && !r_sh_full && out_free;
        o_pop    = (r_state == ST_IDLE) && i_avail;
        wr_en    = o_pop && !i_cmd.is_scan;

        top_idx = rlpsd_pkg::WIDX_W'(int'(r_row) * rlpsd_pkg::ROW_BYTES + int'(r_fgrp));
        bot_idx = rlpsd_pkg::WIDX_W'(int'(top_idx)
                  + rlpsd_pkg::HALF_ROWS * rlpsd_pkg::ROW_BYTES);

        n_out = '0;
        if (sh_adv) begin
            n_out.red_top      = r_sh[0][0];
            n_out.green_top    = r_sh[1][0];
            n_out.blue_top     = r_sh[2][0];
            n_out.red_bottom   = r_sh[3][0];
            n_out.green_bottom = r_sh[4][0];
            n_out.blue_bottom  = r_sh[5][0];
        end else begin
            n_out.row_select   = 3'(r_row);
            n_out.latch_strobe = 1'b1;
            n_out.last         = 1'b1;
        end

        o_valid = r_out_vld;
        o_data  = r_out;
    end

    // memory write, registered group read, shifter and output register
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_cmd.color][i_cmd.widx] <= i_cmd.data;
        end
        if (rd_en) begin
            for (int c = 0; c < rlpsd_pkg::COLORS; c++) begin
                r_rd[c]                    <= r_mem[c][top_idx];
                r_rd[c + rlpsd_pkg::COLORS] <= r_mem[c][bot_idx];
                r_rd_v[c]                    <= r_vld[c][top_idx];
                r_rd_v[c + rlpsd_pkg::COLORS] <= r_vld[c][bot_idx];
            end
        end
        for (int k = 0; k < rlpsd_pkg::LANES; k++) begin
            if (sh_load) begin
                r_sh[k] <= r_rd_v[k] ? r_rd[k] : 8'd0;
            end else if (sh_adv) begin
                r_sh[k] <= {1'b0, r_sh[k][7:1]};
            end
        end
        if (out_free) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < rlpsd_pkg::COLORS; c++) begin
                r_vld[c] <= '0;
            end
            r_state   <= ST_IDLE;
            r_row     <= '0;
            r_fgrp    <= '0;
            r_sgrp    <= '0;
            r_rd_vld  <= 1'b0;
            r_sh_full <= 1'b0;
            r_bit     <= 3'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[i_cmd.color][i_cmd.widx] <= 1'b1;
            end

            if (o_pop && i_cmd.is_scan) begin
                r_state <= ST_SCAN;
                r_fgrp  <= '0;
                r_sgrp  <= '0;
            end else if (latch_go) begin
                r_state <= ST_IDLE;
                r_row   <= r_row + rlpsd_pkg::ROW_W'(1);
            end

            if (rd_en) begin
                r_fgrp <= r_fgrp + rlpsd_pkg::GRP_W'(1);
            end

            if (rd_en) begin
                r_rd_vld <= 1'b1;
            end else if (sh_load) begin
                r_rd_vld <= 1'b0;
            end

            if (sh_load) begin
                r_sh_full <= 1'b1;
                r_bit     <= 3'd0;
            end else if (sh_adv) begin
                r_bit <= r_bit + 3'd1;
                if (sh_last) begin
                    r_sh_full <= 1'b0;
                end
            end

            if (sh_adv && sh_last) begin
                r_sgrp <= r_sgrp + rlpsd_pkg::GRP_W'(1);
            end

            if (out_free) begin
                r_out_vld <= sh_adv || latch_go;
            end
        end
    end

endmodule

`default_nettype wire
